// ===== rtl/mbps_pkg.sv =====
// Shared constants, types and codes of the masked byte pattern search block.
`default_nettype none

package mbps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int LEN_FIELD_W = 7;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int POS_W       = 32;
  localparam int COUNT_W     = 32;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 1'd0,
    CFG_START_POSITION = 1'd1
  } cfg_idx_t;

  // Pattern table write command.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    byte_t            value;
    logic             care;
  } pat_wr_t;

endpackage

`default_nettype wire

// ===== rtl/mbps_in_if.sv =====
// Input item channel: valid/ready handshake with the item fields.
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] entry_index;
  logic [7:0] value;
  logic       care;

  modport source (output valid, output kind, output entry_index, output value,
                  output care, input ready);
  modport sink (input valid, input kind, input entry_index, input value,
                input care, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbps_out_if.sv =====
// Result item channel: valid/ready handshake with the result fields.
`default_nettype none

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbps_window.sv =====
// Byte window shift line and its alignment against the pattern order.
`default_nettype none

module mbps_window
  import mbps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire byte_t            shift_byte,
  input  wire logic [LEN_W-1:0] len,
  output byte_t                 aligned [MAX_PATTERN]
);

  byte_t win_r [MAX_PATTERN];

  // win_r[k] holds the byte received k items ago; only read once filled.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= shift_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  // Pattern entry i lines up with the byte received len-1-i items ago.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < len) begin
        aligned[i] = win_r[IDX_W'(len - LEN_W'(1) - LEN_W'(i))];
      end else begin
        aligned[i] = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbps_matcher.sv =====
// Pattern byte and care tables with the parallel masked compare.
`default_nettype none

module mbps_matcher
  import mbps_pkg::*;
(
  input  wire logic             clk,
  input  wire pat_wr_t          pat_wr,
  input  wire byte_t            aligned [MAX_PATTERN],
  input  wire logic [LEN_W-1:0] len,
  output logic                  hit
);

  byte_t                  pat_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] care_r;
  logic [MAX_PATTERN-1:0] eq;

  always_ff @(posedge clk) begin
    if (pat_wr.en) begin
      pat_r[pat_wr.idx]  <= pat_wr.value;
      care_r[pat_wr.idx] <= pat_wr.care;
    end
  end

  // Entries past the length and wildcard entries always pass.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i] = (LEN_W'(i) >= len) || !care_r[i] || (pat_r[i] == aligned[i]);
    end
  end

  assign hit = &eq;

endmodule

`default_nettype wire

// ===== rtl/masked_byte_pattern_search_core.sv =====
// Top level of the masked byte pattern search block.
`default_nettype none

// Masked byte pattern search. Load items (kind 0) write pattern byte and care
// bit at entry_index; data items (kind 1) stream memory bytes; an end item
// (kind 2) closes the region. The first place in a region where the last
// pattern_length bytes match the pattern (care 0 = wildcard) gives one result
// with found=1 and position = start_position + offset of the match's first
// byte. Later bytes of that region give nothing. An end item gives found=0,
// position=0 if no match was seen, and restarts the scan either way. Kind 3
// is ignored. Throughput is one item per clock: an item is taken into the
// window / pattern registers at acceptance, the masked compare over all
// pattern entries then runs from those registers, and its result lands in
// the output register, which drives result valid. The input stalls only
// while an item in the compare stage faces a full, unread output register.
// Configuration writes (index 0 pattern_length, index 1 start_position)
// belong in idle periods; loads take effect for the next compare even in
// the middle of a region.
module masked_byte_pattern_search_core
  import mbps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  mbps_in_if.sink                   in_ch,
  mbps_out_if.source                out_ch
);

  // configuration
  logic [LEN_FIELD_W-1:0] pat_len_r;
  logic [POS_W-1:0]       start_pos_r;
  logic [LEN_W-1:0]       eff_len;

  // scan state
  logic [COUNT_W-1:0]     seen_r;
  logic                   reported_r;
  logic                   st_valid_r;
  kind_t                  st_kind_r;

  // output register
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [POS_W-1:0]       out_pos_r;

  logic                   accept;
  logic                   out_free;
  logic                   st_go;
  logic                   is_data;
  logic                   is_end;
  logic                   is_load;
  logic                   hit;
  logic                   seen_ok;
  logic                   emit_match;
  logic                   emit_miss;
  logic [POS_W-1:0]       match_pos;
  pat_wr_t                pat_wr;
  byte_t                  aligned [MAX_PATTERN];

  // Length of zero reads as one; above table depth saturates.
  always_comb begin
    if (pat_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(pat_len_r) > MAX_PATTERN) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(pat_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= LEN_FIELD_W'(1);
      start_pos_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_LENGTH: pat_len_r   <= cfg_wdata[LEN_FIELD_W-1:0];
        CFG_START_POSITION: start_pos_r <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the compare stage moves when the output register can take
  // whatever it produces.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign st_go       = st_valid_r && out_free;
  assign in_ch.ready = !st_valid_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    is_load = 1'b0;
    is_data = 1'b0;
    is_end  = 1'b0;
    unique case (kind_t'(in_ch.kind))
      KIND_LOAD: is_load = 1'b1;
      KIND_DATA: is_data = 1'b1;
      KIND_END:  is_end  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    pat_wr.en    = accept && is_load && (32'(in_ch.entry_index) < MAX_PATTERN);
    pat_wr.idx   = IDX_W'(in_ch.entry_index);
    pat_wr.value = in_ch.value;
    pat_wr.care  = in_ch.care;
  end

  mbps_window u_window (
    .clk        (clk),
    .shift_en   (accept && is_data),
    .shift_byte (in_ch.value),
    .len        (eff_len),
    .aligned    (aligned)
  );

  mbps_matcher u_matcher (
    .clk     (clk),
    .pat_wr  (pat_wr),
    .aligned (aligned),
    .len     (eff_len),
    .hit     (hit)
  );

  // Byte count of the region, saturating; cleared by an end item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (accept && is_end) begin
      seen_r <= '0;
    end else if (accept && is_data && (seen_r != '1)) begin
      seen_r <= seen_r + COUNT_W'(1);
    end
  end

  // Compare stage holds the kind of the last data or end item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
      st_kind_r  <= KIND_DATA;
    end else if (accept) begin
      st_valid_r <= is_data || is_end;
      st_kind_r  <= is_end ? KIND_END : KIND_DATA;
    end else if (st_go) begin
      st_valid_r <= 1'b0;
    end
  end

  // Window is full enough once seen_r >= len.
  assign seen_ok    = (seen_r >= COUNT_W'(eff_len));
  assign match_pos  = start_pos_r + (seen_r - COUNT_W'(eff_len));
  assign emit_match = st_go && (st_kind_r == KIND_DATA) && !reported_r && seen_ok && hit;
  assign emit_miss  = st_go && (st_kind_r == KIND_END) && !reported_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r <= 1'b0;
    end else if (st_go && (st_kind_r == KIND_END)) begin
      reported_r <= 1'b0;
    end else if (emit_match) begin
      reported_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_match || emit_miss) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_match) begin
      out_found_r <= 1'b1;
      out_pos_r   <= match_pos;
    end else if (emit_miss) begin
      out_found_r <= 1'b0;
      out_pos_r   <= '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

endmodule

`default_nettype wire
